// ===== sv/htsed_pkg.sv =====
package htsed_pkg;

	localparam int unsigned NSTAGES = 5;
	localparam int unsigned PAT_MAX = 6;
	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_AMP = 8'h26;
	localparam logic [7:0] CH_LT  = 8'h3C;
	localparam logic [7:0] CH_GT  = 8'h3E;

	typedef enum logic {
		KIND_TEXT = 1'b0,
		KIND_EOM  = 1'b1
	} kind_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] in_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       end_of_message;
	} out_item_t;

	// word moved between the internal parts: a text byte or an end marker
	typedef struct packed {
		logic       eom;
		logic [7:0] data;
	} tok_t;

	// &lt; &gt; &amp; &apos; &nbsp;
	localparam logic [7:0] PAT [NSTAGES][PAT_MAX] = '{
		'{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
		'{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
		'{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},
		'{8'h26, 8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B},
		'{8'h26, 8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B}
	};

	localparam logic [2:0] PAT_LEN [NSTAGES] = '{3'd4, 3'd4, 3'd5, 3'd6, 3'd6};

	localparam logic [7:0] REP [NSTAGES] = '{8'h3C, 8'h3E, 8'h26, 8'h27, 8'h20};

endpackage

// ===== sv/htsed_front.sv =====
module htsed_front
	import htsed_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     valid,
	output logic     stall,
	input  in_item_t item,
	output logic     push,
	input  logic     full,
	output tok_t     push_tok
);

	logic in_tag_q;
	logic take;
	logic keep;

	assign stall = full;
	assign take  = valid && !full;

	always_comb begin
		keep = 1'b0;
		if (item.kind == KIND_EOM) begin
			keep = 1'b1;
		end else if (!in_tag_q && item.in_byte != CH_LT) begin
			keep = 1'b1;
		end
	end

	assign push          = take && keep;
	assign push_tok.eom  = (item.kind == KIND_EOM);
	assign push_tok.data = item.in_byte;

	// tag state survives end of message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_tag_q <= 1'b0;
		end else if (take && item.kind == KIND_TEXT) begin
			if (in_tag_q) begin
				if (item.in_byte == CH_GT) begin
					in_tag_q <= 1'b0;
				end
			end else if (item.in_byte == CH_LT) begin
				in_tag_q <= 1'b1;
			end
		end
	end

endmodule

// ===== sv/htsed_queue.sv =====
module htsed_queue
	import htsed_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  tok_t push_tok,
	output logic valid,
	input  logic stall,
	output tok_t tok
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	tok_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          pop;

	assign full  = (count_q == CW'(DEPTH));
	assign valid = (count_q != '0);
	assign tok   = mem_q[rd_ptr_q];
	assign pop   = valid && !stall;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/htsed_stage.sv =====
module htsed_stage
	import htsed_pkg::*;
#(
	parameter int unsigned STAGE_IDX = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  tok_t in_tok,
	output logic out_valid,
	input  logic out_stall,
	output tok_t out_tok
);

	localparam logic [2:0] PLEN = PAT_LEN[STAGE_IDX];
	localparam logic [7:0] RBYTE = REP[STAGE_IDX];

	logic       ovalid_q;
	tok_t       odata_q;
	logic [2:0] prog_q, prog_d;
	logic [2:0] rel_idx_q, rel_idx_d;
	logic [2:0] rel_end_q, rel_end_d;
	logic       pend_q, pend_d;
	tok_t       pend_tok_q, pend_tok_d;
	logic       releasing;
	logic       busy;
	logic       out_free;
	logic       take;
	logic       emit;
	tok_t       emit_tok;

	assign releasing = (rel_idx_q != rel_end_q);
	assign busy      = releasing || pend_q;
	assign out_free  = !ovalid_q || !out_stall;
	assign in_stall  = busy || !out_free;
	assign take      = in_valid && !in_stall;
	assign out_valid = ovalid_q;
	assign out_tok   = odata_q;

	always_comb begin
		prog_d     = prog_q;
		rel_idx_d  = rel_idx_q;
		rel_end_d  = rel_end_q;
		pend_d     = pend_q;
		pend_tok_d = pend_tok_q;
		emit       = 1'b0;
		emit_tok   = '0;
		if (busy) begin
			if (out_free) begin
				emit = 1'b1;
				if (releasing) begin
					emit_tok  = '{eom: 1'b0, data: PAT[STAGE_IDX][rel_idx_q]};
					rel_idx_d = rel_idx_q + 3'd1;
				end else begin
					emit_tok = pend_tok_q;
					pend_d   = 1'b0;
				end
			end
		end else if (take) begin
			if (in_tok.eom) begin
				// flush held prefix, then pass the marker on
				prog_d = '0;
				emit   = 1'b1;
				if (prog_q == '0) begin
					emit_tok = in_tok;
				end else begin
					emit_tok   = '{eom: 1'b0, data: PAT[STAGE_IDX][0]};
					rel_idx_d  = 3'd1;
					rel_end_d  = prog_q;
					pend_d     = 1'b1;
					pend_tok_d = in_tok;
				end
			end else if (in_tok.data == PAT[STAGE_IDX][prog_q]) begin
				if (3'(prog_q + 3'd1) == PLEN) begin
					prog_d   = '0;
					emit     = 1'b1;
					emit_tok = '{eom: 1'b0, data: RBYTE};
				end else begin
					prog_d = prog_q + 3'd1;
				end
			end else if (prog_q == '0) begin
				emit     = 1'b1;
				emit_tok = in_tok;
			end else begin
				// mismatch: release prefix; a fresh '&' restarts the match
				emit      = 1'b1;
				emit_tok  = '{eom: 1'b0, data: PAT[STAGE_IDX][0]};
				rel_idx_d = 3'd1;
				rel_end_d = prog_q;
				if (in_tok.data == CH_AMP) begin
					prog_d = 3'd1;
				end else begin
					prog_d     = '0;
					pend_d     = 1'b1;
					pend_tok_d = in_tok;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			odata_q <= emit_tok;
		end
		pend_tok_q <= pend_tok_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q  <= 1'b0;
			prog_q    <= '0;
			rel_idx_q <= '0;
			rel_end_q <= '0;
			pend_q    <= 1'b0;
		end else begin
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
			prog_q    <= prog_d;
			rel_idx_q <= rel_idx_d;
			rel_end_q <= rel_end_d;
			pend_q    <= pend_d;
		end
	end

endmodule

// ===== sv/html_tag_strip_entity_decode_top.sv =====
// channel  valid      stall      word
// src      src_valid  src_stall  src_item  (kind, in_byte)
// dst      dst_valid  dst_stall  dst_item  (out_byte, has_byte, end_of_message)
//
// One input word per cycle while no stage is busy and dst_stall is low; a '<'
// .. '>' span produces no output words. A replacer stage that releases a held
// prefix stalls its input while it sends the held bytes out and then the
// breaking byte unless it is a fresh '&'; an end marker waits behind the
// bytes held in each stage. Path from src to dst: queue, then five stages.
// Reset clears tag flag, match counts and all valid flags.
module html_tag_strip_entity_decode_top
	import htsed_pkg::*;
#(
	parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_stall,
	input  in_item_t  src_item,
	output logic      dst_valid,
	input  logic      dst_stall,
	output out_item_t dst_item
);

	logic push;
	logic full;
	tok_t push_tok;

	logic ch_valid [NSTAGES+1];
	logic ch_stall [NSTAGES+1];
	tok_t ch_tok   [NSTAGES+1];

	htsed_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (src_valid),
		.stall    (src_stall),
		.item     (src_item),
		.push     (push),
		.full     (full),
		.push_tok (push_tok)
	);

	htsed_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.push_tok (push_tok),
		.valid    (ch_valid[0]),
		.stall    (ch_stall[0]),
		.tok      (ch_tok[0])
	);

	for (genvar g = 0; g < NSTAGES; g++) begin : g_stage
		htsed_stage #(
			.STAGE_IDX (g)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (ch_valid[g]),
			.in_stall  (ch_stall[g]),
			.in_tok    (ch_tok[g]),
			.out_valid (ch_valid[g+1]),
			.out_stall (ch_stall[g+1]),
			.out_tok   (ch_tok[g+1])
		);
	end

	assign ch_stall[NSTAGES] = dst_stall;
	assign dst_valid         = ch_valid[NSTAGES];

	always_comb begin
		dst_item.out_byte       = ch_tok[NSTAGES].eom ? 8'h00 : ch_tok[NSTAGES].data;
		dst_item.has_byte       = !ch_tok[NSTAGES].eom;
		dst_item.end_of_message = ch_tok[NSTAGES].eom;
	end

endmodule
